/* design/tlfr_pkg.sv */
package tlfr_pkg;

	localparam int TAG_LEN_DEF   = 4;
	localparam int TAG_LEN_MAX   = 4;
	localparam int HEADER_BYTES  = 6;
	localparam int NUM_COMMANDS  = 5;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;

	typedef enum logic [1:0] {
		PH_TAG     = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_SPARE   = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_TAG  = 3'd0,
		REG_COMMAND_A = 3'd1,
		REG_COMMAND_B = 3'd2,
		REG_COMMAND_C = 3'd3,
		REG_COMMAND_D = 3'd4,
		REG_COMMAND_E = 3'd5,
		REG_ENABLES   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]                   sync_tag;
		logic [NUM_COMMANDS-1:0][31:0] command;
		logic [NUM_COMMANDS-1:0]       enables;
	} cfg_t;

endpackage

/* design/tlfr_cfg.sv */
module tlfr_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tlfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tlfr_pkg::CFG_DATA_W-1:0] cfg_data,
	output tlfr_pkg::cfg_t                   cfg
);
	import tlfr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_TAG:  cfg_q.sync_tag   <= cfg_data;
				REG_COMMAND_A: cfg_q.command[0] <= cfg_data;
				REG_COMMAND_B: cfg_q.command[1] <= cfg_data;
				REG_COMMAND_C: cfg_q.command[2] <= cfg_data;
				REG_COMMAND_D: cfg_q.command[3] <= cfg_data;
				REG_COMMAND_E: cfg_q.command[4] <= cfg_data;
				REG_ENABLES:   cfg_q.enables    <= cfg_data[NUM_COMMANDS-1:0];
				default: ; // unmapped index, dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/tlfr_core.sv */
module tlfr_core #(
	parameter int TAG_LEN = tlfr_pkg::TAG_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tlfr_pkg::cfg_t cfg,
	input  logic           valid_s1,
	input  logic [7:0]     byte_s1,
	output logic           advance,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     payload_byte,
	output logic [31:0]    frame_command,
	output logic [15:0]    frame_length,
	output logic           last_of_frame,
	output logic           empty_frame
);
	import tlfr_pkg::*;

	localparam logic [15:0] TAG_LEN_W = 16'(TAG_LEN);
	localparam logic [15:0] HDR_W     = 16'(HEADER_BYTES);

	phase_t      phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] len_q, len_d;
	logic [31:0] cmd_q, cmd_d;

	logic        res_v;
	logic [7:0]  res_byte;
	logic [31:0] res_cmd;
	logic [15:0] res_len;
	logic        res_last, res_empty;

	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic [31:0] cmd_out_q;
	logic [15:0] len_out_q;
	logic        last_q, empty_q;

	logic [15:0] pos_inc;
	logic [7:0]  want;
	logic [15:0] hdr_len;
	logic [31:0] hdr_cmd;
	logic        hdr_done;
	logic        cmd_hit;

	assign advance  = !out_valid_q || !out_stall;
	assign pos_inc  = pos_q + 16'd1;
	assign want     = cfg.sync_tag[{pos_q[1:0], 3'b000} +: 8];
	assign hdr_done = pos_inc >= HDR_W;

	// header byte lands in the length or command field picked by position
	always_comb begin
		hdr_len = len_q;
		hdr_cmd = cmd_q;
		case (pos_q[2:0])
			3'd0: hdr_len[7:0]   = byte_s1;
			3'd1: hdr_len[15:8]  = byte_s1;
			3'd2: hdr_cmd[7:0]   = byte_s1;
			3'd3: hdr_cmd[15:8]  = byte_s1;
			3'd4: hdr_cmd[23:16] = byte_s1;
			3'd5: hdr_cmd[31:24] = byte_s1;
			default: ;
		endcase
	end

	// command check sees the header including the byte being taken
	always_comb begin
		cmd_hit = 1'b0;
		for (int k = 0; k < NUM_COMMANDS; k++)
			if (cfg.enables[k] && cfg.command[k] == hdr_cmd)
				cmd_hit = 1'b1;
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		len_d   = len_q;
		cmd_d   = cmd_q;
		unique case (phase_q)
			PH_PAYLOAD: begin
				pos_d = pos_inc;
				if (pos_inc == len_q) begin
					phase_d = PH_TAG;
					pos_d   = '0;
				end
			end
			PH_HEADER: begin
				len_d = hdr_len;
				cmd_d = hdr_cmd;
				pos_d = pos_inc;
				if (hdr_done) begin
					pos_d = '0;
					if (cmd_hit && hdr_len != '0) begin
						phase_d = PH_PAYLOAD;
					end else begin
						phase_d = PH_TAG;
					end
				end
			end
			PH_TAG: begin
				if (pos_q < TAG_LEN_W && byte_s1 == want) begin
					pos_d = pos_inc;
					if (pos_inc >= TAG_LEN_W) begin
						phase_d = PH_HEADER;
						pos_d   = '0;
						len_d   = '0;
						cmd_d   = '0;
					end
				end else begin
					pos_d = '0;
				end
			end
			default: begin
				// spare code: behave as a fresh hunt
				phase_d = PH_TAG;
				pos_d   = '0;
				if (byte_s1 == cfg.sync_tag[7:0]) begin
					pos_d = 16'd1;
					if (16'd1 >= TAG_LEN_W) begin
						phase_d = PH_HEADER;
						pos_d   = '0;
						len_d   = '0;
						cmd_d   = '0;
					end
				end
			end
		endcase
	end

	// result for the byte in the input register
	always_comb begin
		res_v     = 1'b0;
		res_byte  = byte_s1;
		res_cmd   = cmd_q;
		res_len   = len_q;
		res_last  = 1'b0;
		res_empty = 1'b0;
		unique case (phase_q)
			PH_PAYLOAD: begin
				res_v    = 1'b1;
				res_last = (pos_inc == len_q);
			end
			PH_HEADER: begin
				// accepted zero-length frame: one empty marker
				if (hdr_done && cmd_hit && hdr_len == '0) begin
					res_v     = 1'b1;
					res_byte  = '0;
					res_cmd   = hdr_cmd;
					res_len   = hdr_len;
					res_last  = 1'b1;
					res_empty = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TAG;
			pos_q       <= '0;
			len_q       <= '0;
			cmd_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_v;
			if (valid_s1) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				len_q   <= len_d;
				cmd_q   <= cmd_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_v) begin
			byte_q    <= res_byte;
			cmd_out_q <= res_cmd;
			len_out_q <= res_len;
			last_q    <= res_last;
			empty_q   <= res_empty;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = byte_q;
	assign frame_command = cmd_out_q;
	assign frame_length  = len_out_q;
	assign last_of_frame = last_q;
	assign empty_frame   = empty_q;

endmodule

/* design/tagged_length_frame_receiver_unit.sv */
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_stall    rx_byte
// out       out  out_valid/out_stall  payload_byte, frame_command, frame_length,
//                                     last_of_frame, empty_frame
// cfg       in   cfg_we               cfg_index, cfg_data
//
// One input transaction per cycle while in_stall is low; a taken byte's result
// reaches the outputs through the input register, then the result register.
// Throughput is set by the combinational parser update between the two registers.
// arst_n clears config, parser state and both valid flags.
// While a result is held under out_stall, at most one more byte is taken into
// the input register; after that in_stall rises until the result drains.
module tagged_length_frame_receiver_unit #(
	parameter int TAG_LEN = tlfr_pkg::TAG_LEN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       rx_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       payload_byte,
	output logic [31:0]                      frame_command,
	output logic [15:0]                      frame_length,
	output logic                             last_of_frame,
	output logic                             empty_frame,
	input  logic                             cfg_we,
	input  logic [tlfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tlfr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tlfr_pkg::*;

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	// input stage stalls only when it is full and the parser cannot consume it
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	tlfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// tag hunt, header capture, command check and payload tagging
	tlfr_core #(
		.TAG_LEN (TAG_LEN)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.valid_s1      (valid_s1),
		.byte_s1       (byte_s1),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.frame_command (frame_command),
		.frame_length  (frame_length),
		.last_of_frame (last_of_frame),
		.empty_frame   (empty_frame)
	);

endmodule

/* tb/sv/tagged_length_frame_receiver_unit_tb.sv */
module tagged_length_frame_receiver_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tlfr_pkg::*;

	// Index 7 has no register behind it; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int TAG_BYTES = TAG_LEN_DEF;
	// Cycles from an accepted byte until its result could show up, with margin.
	localparam int SETTLE_CYCLES = 6;

	typedef struct packed {
		logic [7:0]  data;
		logic [31:0] command;
		logic [15:0] length;
		logic        last;
		logic        empty;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  payload_byte;
	logic [31:0] frame_command;
	logic [15:0] frame_length;
	logic        last_of_frame;
	logic        empty_frame;
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tagged_length_frame_receiver_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.frame_command (frame_command),
		.frame_length  (frame_length),
		.last_of_frame (last_of_frame),
		.empty_frame   (empty_frame),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Shadow of the parser: register copy plus frame state.
	cfg_t        rx_cfg = '0;
	phase_t      rx_phase = PH_TAG;
	logic [15:0] rx_pos = '0;
	logic [15:0] rx_len = '0;
	logic [31:0] rx_cmd = '0;

	frame_result_t pending_results[$];

	// Random idling on each side; the hold-off request is picked up by the
	// stall process and counted down there.
	bit in_gaps = 1'b1;
	bit out_gaps = 1'b1;
	int hold_request = 0;
	int hold_left = 0;

	int sent_count = 0;
	int results_checked = 0;
	int frames_accepted = 0;
	int empty_frames = 0;
	int held_off_cycles = 0;
	int errors = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Parser step for one accepted byte; queues the result it causes, if any.
	function automatic void parse_byte(input logic [7:0] b);
		frame_result_t r;
		logic [2:0]    hp;
		logic          hit;
		logic [7:0]    want;
		r = '0;
		case (rx_phase)
		PH_PAYLOAD: begin
			rx_pos = rx_pos + 16'd1;
			r.data = b;
			r.command = rx_cmd;
			r.length = rx_len;
			r.last = (rx_pos == rx_len);
			if (r.last) begin
				rx_phase = PH_TAG;
				rx_pos = '0;
			end
			pending_results.push_back(r);
		end
		PH_HEADER: begin
			hp = rx_pos[2:0];
			if (hp == 3'd0)
				rx_len[7:0] = b;
			else if (hp == 3'd1)
				rx_len[15:8] = b;
			else if (hp < HEADER_BYTES)
				rx_cmd[8 * (int'(hp) - 2) +: 8] = b;
			rx_pos = rx_pos + 16'd1;
			if (rx_pos >= HEADER_BYTES) begin
				rx_pos = '0;
				hit = 1'b0;
				for (int k = 0; k < NUM_COMMANDS; k++)
					if (rx_cfg.enables[k] && rx_cfg.command[k] == rx_cmd)
						hit = 1'b1;
				if (!hit) begin
					rx_phase = PH_TAG;
				end else if (rx_len != 0) begin
					rx_phase = PH_PAYLOAD;
					frames_accepted++;
				end else begin
					// zero-length frame: one marker result
					rx_phase = PH_TAG;
					frames_accepted++;
					empty_frames++;
					r.command = rx_cmd;
					r.length = rx_len;
					r.last = 1'b1;
					r.empty = 1'b1;
					pending_results.push_back(r);
				end
			end
		end
		default: begin
			// spare code falls back to hunting from the start
			if (rx_phase != PH_TAG) begin
				rx_phase = PH_TAG;
				rx_pos = '0;
			end
			want = rx_cfg.sync_tag[8 * int'(rx_pos[1:0]) +: 8];
			// a mismatching byte is not retried as a first tag byte
			if (rx_pos < TAG_BYTES && b == want) begin
				rx_pos = rx_pos + 16'd1;
				if (rx_pos >= TAG_BYTES) begin
					rx_phase = PH_HEADER;
					rx_pos = '0;
					rx_len = '0;
					rx_cmd = '0;
				end
			end else begin
				rx_pos = '0;
			end
		end
		endcase
	endfunction

	// Result checker: oldest expectation against each accepted transaction.
	always @(posedge clk) begin
		frame_result_t want, got;
		if (arst_n && in_valid && in_stall)
			held_off_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			got = '{payload_byte, frame_command, frame_length, last_of_frame, empty_frame};
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: byte=%02h cmd=%08h len=%0d last=%0b empty=%0b",
						got.data, got.command, got.length, got.last, got.empty);
			end else begin
				want = pending_results.pop_front();
				if (got.data !== want.data || got.command !== want.command ||
				    got.length !== want.length || got.last !== want.last ||
				    got.empty !== want.empty) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch: expected byte=%02h cmd=%08h len=%0d last=%0b empty=%0b",
							want.data, want.command, want.length, want.last, want.empty);
						$display("          got      byte=%02h cmd=%08h len=%0d last=%0b empty=%0b",
							got.data, got.command, got.length, got.last, got.empty);
					end
				end
			end
			results_checked++;
		end
	end

	// Receiver side: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= out_gaps && ($urandom_range(99) < 10);
		end
	end

	// All tasks below start and end at a falling edge.
	task automatic send_byte(input logic [7:0] b);
		if (in_gaps)
			while ($urandom_range(99) < 10) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		parse_byte(b);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_header(input logic [15:0] len, input logic [31:0] cmd);
		for (int i = 0; i < TAG_BYTES; i++)
			send_byte(rx_cfg.sync_tag[8 * i +: 8]);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		for (int i = 0; i < 4; i++)
			send_byte(cmd[8 * i +: 8]);
	endtask

	task automatic send_frame(input logic [15:0] len, input logic [31:0] cmd);
		send_header(len, cmd);
		for (int i = 0; i < int'(len); i++)
			send_byte(8'($urandom));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
		REG_SYNC_TAG:
			rx_cfg.sync_tag = data;
		REG_COMMAND_A, REG_COMMAND_B, REG_COMMAND_C, REG_COMMAND_D, REG_COMMAND_E:
			rx_cfg.command[int'(idx) - int'(REG_COMMAND_A)] = data;
		REG_ENABLES:
			rx_cfg.enables = data[NUM_COMMANDS-1:0];
		default: ;
		endcase
		@(negedge clk);
	endtask

	// Full register load. Enables get junk in the upper bits (must be masked),
	// and the unused index gets a write that must change nothing.
	task automatic load_settings(input logic [31:0] tag,
	                             input logic [NUM_COMMANDS-1:0][31:0] cmds,
	                             input logic [NUM_COMMANDS-1:0] en);
		write_reg(REG_SYNC_TAG, tag);
		for (int k = 0; k < NUM_COMMANDS; k++)
			write_reg(reg_idx_t'(int'(REG_COMMAND_A) + k), cmds[k]);
		write_reg(REG_ENABLES, ($urandom & ~32'h1F) | 32'(en));
		write_reg(REG_UNUSED, $urandom);
		cfg_we <= 1'b0;
	endtask

	// Block is idle once every result is in and trailing bytes have settled.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic test_directed();
		logic [NUM_COMMANDS-1:0][31:0] cmds;
		cmds[0] = 32'hFFFF_FFFF;
		cmds[1] = 32'h1234_5678;
		cmds[2] = 32'h0000_0000;
		cmds[3] = 32'hC3C3_3C3C;
		cmds[4] = 32'h8000_0001;
		// only words a and c are live
		load_settings(32'h5AFF_00A5, cmds, 5'b00101);
		// empty frame on an all-ones command
		send_frame(16'd0, cmds[0]);
		// repeated first tag byte: the second one is not retried, so no sync
		send_byte(8'hA5);
		send_byte(8'hA5);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);
		// two-byte frame on the all-zero command, payload at both extremes
		send_header(16'd2, cmds[2]);
		send_byte(8'h00);
		send_byte(8'hFF);
		wait_idle();
	endtask

	task automatic test_back_pressure();
		in_gaps = 1'b0;
		out_gaps = 1'b0;
		hold_request = 80;
		send_frame(16'd40, rx_cfg.command[2]);
		wait_idle();
		in_gaps = 1'b1;
		out_gaps = 1'b1;
	endtask

	// Mostly well-formed frames with random content, some noise and
	// truncated frames in between.
	task automatic random_traffic(input int n_bytes);
		int stop_at;
		int pick;
		int len;
		logic [31:0] cmd;
		stop_at = sent_count + n_bytes;
		while (sent_count < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
				cmd = ($urandom_range(4) == 0) ? $urandom
				    : rx_cfg.command[$urandom_range(NUM_COMMANDS - 1)];
				send_frame(16'(len), cmd);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end else begin
				// truncated tag, then stray bytes
				len = $urandom_range(1, TAG_BYTES - 1);
				for (int i = 0; i < len; i++)
					send_byte(rx_cfg.sync_tag[8 * i +: 8]);
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
			end
		end
	endtask

	task automatic test_random();
		logic [NUM_COMMANDS-1:0][31:0] cmds;
		logic [31:0] tag;
		logic [NUM_COMMANDS-1:0] en;
		for (int p = 0; p < 5; p++) begin
			for (int k = 0; k < NUM_COMMANDS; k++)
				cmds[k] = $urandom;
			case (p)
			0: begin
				tag = 32'h0000_0000;
				en = 5'h1F;
			end
			1: begin
				tag = 32'hFFFF_FFFF;
				cmds[0] = 32'h0000_0000;
				cmds[1] = 32'hFFFF_FFFF;
				en = 5'($urandom_range(1, 31));
			end
			2: begin
				// nothing enabled: every frame dropped
				tag = $urandom;
				en = 5'h00;
			end
			default: begin
				tag = $urandom;
				en = 5'($urandom_range(1, 31));
			end
			endcase
			// phase 3 runs with no idling on either side
			in_gaps = (p != 3);
			out_gaps = (p != 3);
			load_settings(tag, cmds, en);
			random_traffic(70);
			wait_idle();
		end
		in_gaps = 1'b1;
		out_gaps = 1'b1;
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_back_pressure();
		test_random();
		out_gaps = 1'b0;
		if (pending_results.size() != 0) begin
			errors++;
			$display("%0d expected results never arrived", pending_results.size());
		end
		$display("sent %0d bytes, checked %0d results from %0d frames (%0d empty)",
			sent_count, results_checked, frames_accepted, empty_frames);
		$display("input held off for %0d cycles under output back-pressure", held_off_cycles);
		if (errors == 0)
			$display("tagged_length_frame_receiver_unit regression: pass");
		else
			$display("tagged_length_frame_receiver_unit regression: fail");
		$finish;
	end

	// Timeout in case the run never finishes.
	initial begin
		#200_000;
		$display("tagged_length_frame_receiver_unit regression: fail");
		$finish;
	end

endmodule

/* files.f */
design/tlfr_pkg.sv
design/tlfr_cfg.sv
design/tlfr_core.sv
design/tagged_length_frame_receiver_unit.sv
tb/sv/tagged_length_frame_receiver_unit_tb.sv
